FILE: rtl/core/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Types and constants shared by the ball packet parser modules.
// ----------------------------------------------------------------------------
package bpp_pkg;

    localparam logic [7:0] CH_END   = 8'h42;  // 'B'
    localparam logic [7:0] CH_START = 8'h62;  // 'b'
    localparam logic [7:0] CH_TAIL  = 8'h49;  // 'I'
    localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] FRAME_LEN     = 4'd9;
    localparam logic [3:0] FRAME_LEN_SAT = 4'd15;
    localparam logic [9:0] ANGLE_SAT     = 10'd1023;
    localparam logic [9:0] DIST_SAT      = 10'd511;
    localparam logic [9:0] ANGLE_LIMIT   = 10'd360;
    localparam logic [8:0] DIST_LIMIT    = 9'd250;
    localparam logic [8:0] HALF_TURN     = 9'd180;

    localparam logic [8:0] FRONT_MIN_RESET = 9'd340;
    localparam logic [8:0] FRONT_MAX_RESET = 9'd20;
    localparam logic [7:0] NEAR_RESET      = 8'd100;
    localparam logic [7:0] FAR_RESET       = 8'd150;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        CFG_FRONT_MIN = 2'd0,
        CFG_FRONT_MAX = 2'd1,
        CFG_MOUTH_NEAR = 2'd2,
        CFG_MOUTH_FAR = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [8:0] compass_angle;
    } in_beat_t;

    typedef struct packed {
        logic [8:0] ball_angle;
        logic [8:0] ball_angle_fixed;
        logic [7:0] ball_distance;
        logic       ball_seen;
        logic       frame_ok;
        logic       in_front;
        logic       in_mouth;
        logic       in_mouth_far;
    } out_beat_t;

    // one closed frame, handed from the parser to the update stage
    typedef struct packed {
        logic       frame_ok;
        logic [8:0] angle;
        logic [7:0] distance;
        logic [8:0] heading;
    } frame_rec_t;

    typedef struct packed {
        logic [8:0] front_min_angle;
        logic [8:0] front_max_angle;
        logic [7:0] mouth_near_distance;
        logic [7:0] mouth_far_distance;
    } cfg_regs_t;

endpackage

FILE: rtl/core/bpp_front.sv
// ----------------------------------------------------------------------------
// bpp_front
// Byte parser: tracks the open frame and emits a frame record at each 'B'.
// ----------------------------------------------------------------------------
module bpp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_valid,
    input  bpp_pkg::in_beat_t  beat,
    output logic               rec_push,
    output bpp_pkg::frame_rec_t rec
);
    import bpp_pkg::*;

    logic [3:0] len_reg, len_next;
    logic       first_b_reg, first_b_next;
    logic       last_i_reg, last_i_next;
    logic [1:0] dash_reg, dash_next;
    logic       bad_reg, bad_next;
    logic [9:0] angle_reg, angle_next;
    logic [8:0] dist_reg, dist_next;
    logic       is_end;
    logic       ok;

    function automatic logic [9:0] push_digit(input logic [9:0] acc,
                                              input logic [7:0] ch,
                                              input logic [9:0] sat);
        logic [13:0] v;
        begin
            v = {4'b0, acc} * 14'd10 + {6'b0, ch - CH_ZERO};
            return (v > {4'b0, sat}) ? sat : v[9:0];
        end
    endfunction

    assign is_end = (beat.rx_byte == CH_END);

    always_comb begin
        len_next     = len_reg;
        first_b_next = first_b_reg;
        last_i_next  = last_i_reg;
        dash_next    = dash_reg;
        bad_next     = bad_reg;
        angle_next   = angle_reg;
        dist_next    = dist_reg;
        if (beat_valid) begin
            if (is_end) begin
                len_next     = '0;
                first_b_next = 1'b0;
                last_i_next  = 1'b0;
                dash_next    = '0;
                bad_next     = 1'b0;
                angle_next   = '0;
                dist_next    = '0;
            end else begin
                if (len_reg == '0) begin
                    first_b_next = (beat.rx_byte == CH_START);
                end
                if (len_reg != FRAME_LEN_SAT) begin
                    len_next = len_reg + 4'd1;
                end
                // an 'I' followed by more content was not the tail
                bad_next    = bad_reg | last_i_reg;
                last_i_next = 1'b0;
                case (beat.rx_byte) inside
                    CH_START: begin
                        if (dash_reg != '0) begin
                            bad_next = 1'b1;
                        end else begin
                            bad_next   = 1'b0;
                            angle_next = '0;
                        end
                    end
                    CH_DASH: begin
                        if (dash_reg != '0) begin
                            bad_next = 1'b1;
                        end
                        if (dash_reg != 2'd2) begin
                            dash_next = dash_reg + 2'd1;
                        end
                    end
                    [CH_ZERO:CH_NINE]: begin
                        if (dash_reg == '0) begin
                            angle_next = push_digit(angle_reg, beat.rx_byte, ANGLE_SAT);
                        end else begin
                            dist_next = 9'(push_digit({1'b0, dist_reg}, beat.rx_byte,
                                                      DIST_SAT));
                        end
                    end
                    CH_TAIL: begin
                        last_i_next = 1'b1;
                    end
                    default: begin
                        bad_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            first_b_reg <= 1'b0;
            last_i_reg  <= 1'b0;
            dash_reg    <= '0;
            bad_reg     <= 1'b0;
            angle_reg   <= '0;
            dist_reg    <= '0;
        end else begin
            len_reg     <= len_next;
            first_b_reg <= first_b_next;
            last_i_reg  <= last_i_next;
            dash_reg    <= dash_next;
            bad_reg     <= bad_next;
            angle_reg   <= angle_next;
            dist_reg    <= dist_next;
        end
    end

    assign ok = (len_reg == FRAME_LEN) && first_b_reg && last_i_reg &&
                (dash_reg == 2'd1) && !bad_reg &&
                (angle_reg < ANGLE_LIMIT) && (dist_reg <= DIST_LIMIT);

    assign rec_push     = beat_valid && is_end;
    assign rec.frame_ok = ok;
    assign rec.angle    = angle_reg[8:0];
    assign rec.distance = dist_reg[7:0];
    assign rec.heading  = beat.compass_angle;

endmodule

FILE: rtl/core/bpp_queue.sv
// ----------------------------------------------------------------------------
// bpp_queue
// Small first-in first-out store of frame records between parser and update.
// ----------------------------------------------------------------------------
module bpp_queue #(
    parameter int Depth = bpp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bpp_pkg::frame_rec_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output bpp_pkg::frame_rec_t head_data
);
    import bpp_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    frame_rec_t          mem [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;

    assign full       = (count_reg == FullCnt);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/bpp_back.sv
// ----------------------------------------------------------------------------
// bpp_back
// Update stage: folds frame records into the held ball state and drives the
// registered result beat.
// ----------------------------------------------------------------------------
module bpp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpp_pkg::cfg_regs_t  cfg,
    input  logic                rec_valid,
    input  bpp_pkg::frame_rec_t rec,
    output logic                rec_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output bpp_pkg::out_beat_t  m_data
);
    import bpp_pkg::*;

    logic [8:0]  angle_reg, angle_next;
    logic [8:0]  fixed_reg, fixed_next;
    logic [7:0]  dist_reg, dist_next;
    logic        seen_reg, seen_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_reg, out_next;
    logic [10:0] sum;
    logic [10:0] sum_wrapped;
    logic        front;

    assign rec_pop = rec_valid && (!out_valid_reg || m_ready);

    // a heading at or below a half turn gets +360; the sum is then wrapped by 360
    always_comb begin
        sum = {2'b0, rec.angle} + {2'b0, rec.heading};
        if (rec.heading <= HALF_TURN) begin
            sum = sum + {1'b0, ANGLE_LIMIT};
        end
        if (sum >= {ANGLE_LIMIT, 1'b0}) begin
            sum_wrapped = sum - {ANGLE_LIMIT, 1'b0};
        end else if (sum >= {1'b0, ANGLE_LIMIT}) begin
            sum_wrapped = sum - {1'b0, ANGLE_LIMIT};
        end else begin
            sum_wrapped = sum;
        end
    end

    always_comb begin
        angle_next = angle_reg;
        fixed_next = fixed_reg;
        dist_next  = dist_reg;
        seen_next  = seen_reg;
        if (rec_pop && rec.frame_ok) begin
            angle_next = rec.angle;
            fixed_next = sum_wrapped[8:0];
            dist_next  = rec.distance;
            seen_next  = 1'b1;
        end
    end

    assign front = seen_next && ((angle_next > cfg.front_min_angle) ||
                                 (angle_next < cfg.front_max_angle));

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (rec_pop) begin
            out_valid_next            = 1'b1;
            out_next.ball_angle       = angle_next;
            out_next.ball_angle_fixed = fixed_next;
            out_next.ball_distance    = dist_next;
            out_next.ball_seen        = seen_next;
            out_next.frame_ok         = rec.frame_ok;
            out_next.in_front         = front;
            out_next.in_mouth         = front && (dist_next <= cfg.mouth_near_distance);
            out_next.in_mouth_far     = front && (dist_next <= cfg.mouth_far_distance);
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg     <= '0;
            fixed_reg     <= '0;
            dist_reg      <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            angle_reg     <= angle_next;
            fixed_reg     <= fixed_next;
            dist_reg      <= dist_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/core/ball_packet_parser_top.sv
// ----------------------------------------------------------------------------
// ball_packet_parser_top
// Ball packet parser: serial frame decode with held ball state and flags.
// ----------------------------------------------------------------------------
// One byte beat is taken every clock cycle while the frame queue (QueueDepth
// entries, two by default) has room; a full queue holds off every byte, not
// only the frame-end byte 'B'. A 'B' pushes a frame record into the queue, and
// its result beat is valid on the m_ side from the edge at which the record
// leaves the queue, at the head and with the output register free. Sustained
// rate is one beat per cycle while the queue has room; the output register and
// the queue let the parser keep running while a result waits. The threshold
// registers are read when a result is formed.
module ball_packet_parser_top #(
    parameter int QueueDepth = bpp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bpp_pkg::in_beat_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bpp_pkg::out_beat_t    m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  bpp_pkg::cfg_index_t   cfg_index,
    input  logic [8:0]            cfg_data
);
    import bpp_pkg::*;

    cfg_regs_t  cfg_reg, cfg_next;
    logic       q_full;
    logic       rec_push;
    frame_rec_t push_rec;
    logic       head_valid;
    frame_rec_t head_rec;
    logic       rec_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FRONT_MIN:  cfg_next.front_min_angle     = cfg_data;
                CFG_FRONT_MAX:  cfg_next.front_max_angle     = cfg_data;
                CFG_MOUTH_NEAR: cfg_next.mouth_near_distance = cfg_data[7:0];
                CFG_MOUTH_FAR:  cfg_next.mouth_far_distance  = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.front_min_angle     <= FRONT_MIN_RESET;
            cfg_reg.front_max_angle     <= FRONT_MAX_RESET;
            cfg_reg.mouth_near_distance <= NEAR_RESET;
            cfg_reg.mouth_far_distance  <= FAR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !q_full;

    bpp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (s_valid && s_ready),
        .beat       (s_data),
        .rec_push   (rec_push),
        .rec        (push_rec)
    );

    bpp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rec_push),
        .push_data  (push_rec),
        .full       (q_full),
        .pop        (rec_pop),
        .head_valid (head_valid),
        .head_data  (head_rec)
    );

    bpp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec_valid (head_valid),
        .rec       (head_rec),
        .rec_pop   (rec_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
